>>> rtl/core/tlvd_pkg.sv
// Shared types and constants for the TLV message deframer.
// No dependencies; imported by every module of the block.
package tlvd_pkg;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_PTR_W = 3;
	localparam int unsigned FIFO_CNT_W = 4;

	localparam logic [31:0] HDR_BYTES       = 32'd10;
	localparam logic [31:0] HDR_POS_VERSION = 32'd0;
	localparam logic [31:0] HDR_POS_TYPE    = 32'd1;
	localparam logic [31:0] HDR_POS_LAST    = 32'd9;
	localparam logic [31:0] REC_HDR_BYTES   = 32'd5;
	localparam logic [2:0]  FIDX_TAG        = 3'd0;
	localparam logic [2:0]  FIDX_LAST       = 3'd4;
	localparam logic [63:0] BODY_MAX        = 64'h0000_0000_FFFF_FFF5;
	localparam logic [31:0] POS_MAX         = 32'hFFFF_FFFF;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_LENGTH  = 2'd1;
	localparam logic [1:0] ST_VERSION = 2'd2;
	localparam logic [1:0] ST_TYPE    = 2'd3;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] CFG_MAX_RECORDS  = 2'd0;
	localparam logic [1:0] CFG_CHECK_ENABLE = 2'd1;
	localparam logic [1:0] CFG_EXP_VERSION  = 2'd2;
	localparam logic [1:0] CFG_EXP_TYPE     = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_RECHDR,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  record_tag;
		logic [31:0] value_length;
		logic [31:0] value_offset;
		logic [1:0]  status;
		logic [7:0]  record_count;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] max_records;
		logic       check_enable;
		logic [7:0] expected_version;
		logic [7:0] expected_type;
	} cfg_t;

	// up to two results per byte: record first, then status
	typedef struct packed {
		logic      rec_valid;
		out_item_t rec;
		logic      sts_valid;
		out_item_t sts;
	} push_t;

endpackage

>>> rtl/core/tlvd_parser.sv
// Message parse state and per-byte result generation.
// Depends on tlvd_pkg.
module tlvd_parser
	import tlvd_pkg::*;
#(
	parameter int unsigned RECORD_COUNT_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid,
	input  in_item_t item,
	input  cfg_t     cfg,
	output push_t    push
);

	localparam logic [16:0] CAP_LIM = 17'((1 << RECORD_COUNT_BITS) - 1);

	phase_t                       phase_q, phase_step;
	logic [31:0]                  bpos_q, bpos_step;
	logic [63:0]                  decl_q, decl_step;
	logic [2:0]                   fidx_q, fidx_step;
	logic [7:0]                   tag_q, tag_step;
	logic [31:0]                  acc_q, acc_step;
	logic [31:0]                  vleft_q, vleft_step;
	logic [31:0]                  brem_q, brem_step;
	logic [RECORD_COUNT_BITS-1:0] rec_q, rec_step;
	logic                         vbad_q, vbad_step;
	logic                         tbad_q, tbad_step;
	logic                         lbad_q, lbad_step;

	logic [7:0]                   b;
	logic [63:0]                  decl_shift;
	logic [31:0]                  len_new;
	logic [31:0]                  left_after;
	logic                         len_gt;
	logic [31:0]                  rest;
	logic [RECORD_COUNT_BITS-1:0] rec_inc;
	logic [7:0]                   cap8;
	logic [16:0]                  cap;
	logic                         rec_full;
	logic                         rec_hdr_done;
	logic                         emit_rec;
	logic [RECORD_COUNT_BITS+7:0] rec_wide;

	assign b            = item.data_byte;
	assign decl_shift   = {decl_q[55:0], b};
	assign len_new      = {acc_q[23:0], b};
	assign left_after   = brem_q - 32'd1;
	assign len_gt       = len_new > left_after;
	assign rest         = left_after - len_new;
	assign rec_inc      = rec_q + RECORD_COUNT_BITS'(1);
	assign cap8         = (cfg.max_records == 8'd0) ? 8'd1 : cfg.max_records;
	assign cap          = (17'(cap8) > CAP_LIM) ? CAP_LIM : 17'(cap8);
	assign rec_full     = 17'(rec_inc) >= cap;
	assign rec_hdr_done = (phase_q == PH_RECHDR) && (fidx_q == FIDX_LAST);
	assign emit_rec     = valid && rec_hdr_done && !len_gt && !vbad_q && !tbad_q && !lbad_q;

	// next values for one byte, before the end-of-message clear
	always_comb begin
		phase_step = phase_q;
		bpos_step  = bpos_q;
		decl_step  = decl_q;
		fidx_step  = fidx_q;
		tag_step   = tag_q;
		acc_step   = acc_q;
		vleft_step = vleft_q;
		brem_step  = brem_q;
		rec_step   = rec_q;
		vbad_step  = vbad_q;
		tbad_step  = tbad_q;
		lbad_step  = lbad_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (bpos_q == HDR_POS_VERSION) begin
					if (cfg.check_enable && b != cfg.expected_version) vbad_step = 1'b1;
				end else if (bpos_q == HDR_POS_TYPE) begin
					if (cfg.check_enable && b != cfg.expected_type) tbad_step = 1'b1;
				end else begin
					decl_step = decl_shift;
				end
				if (bpos_q == HDR_POS_LAST) begin
					brem_step = decl_shift[31:0];
					if (decl_shift > BODY_MAX) begin
						lbad_step  = 1'b1;
						phase_step = PH_DONE;
					end else if (decl_shift == 64'd0) begin
						phase_step = PH_DONE;
					end else begin
						phase_step = PH_RECHDR;
						fidx_step  = FIDX_TAG;
					end
				end
			end
			PH_RECHDR: begin
				brem_step = left_after;
				if (fidx_q == FIDX_TAG) begin
					if (brem_q < REC_HDR_BYTES) begin
						lbad_step  = 1'b1;
						phase_step = PH_DONE;
					end else begin
						tag_step  = b;
						acc_step  = 32'd0;
						fidx_step = fidx_q + 3'd1;
					end
				end else begin
					acc_step  = len_new;
					fidx_step = fidx_q + 3'd1;
					if (fidx_q == FIDX_LAST) begin
						fidx_step = FIDX_TAG;
						if (len_gt) begin
							lbad_step  = 1'b1;
							phase_step = PH_DONE;
						end else begin
							rec_step = rec_inc;
							if (rec_full) begin
								if (rest != 32'd0) lbad_step = 1'b1;
								phase_step = PH_DONE;
							end else if (len_new != 32'd0) begin
								vleft_step = len_new;
								phase_step = PH_VALUE;
							end else if (rest == 32'd0) begin
								phase_step = PH_DONE;
							end
						end
					end
				end
			end
			PH_VALUE: begin
				brem_step  = left_after;
				vleft_step = vleft_q - 32'd1;
				if (vleft_step == 32'd0) begin
					phase_step = (left_after == 32'd0) ? PH_DONE : PH_RECHDR;
					fidx_step  = FIDX_TAG;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		if (bpos_q == POS_MAX) lbad_step = 1'b1;
		else bpos_step = bpos_q + 32'd1;
	end

	assign rec_wide = {8'd0, rec_step};

	always_comb begin
		push = '0;
		push.rec_valid          = emit_rec;
		push.rec.result_kind    = KIND_RECORD;
		push.rec.record_tag     = tag_q;
		push.rec.value_length   = len_new;
		push.rec.value_offset   = bpos_q + 32'd1;
		push.rec.status         = ST_OK;
		push.rec.record_count   = 8'd0;
		push.rec.last           = 1'b0;
		push.sts_valid          = valid && item.end_of_message;
		push.sts.result_kind    = KIND_STATUS;
		push.sts.last           = 1'b1;
		priority if (bpos_step < HDR_BYTES) begin
			push.sts.status = ST_LENGTH;
		end else if (vbad_step) begin
			push.sts.status = ST_VERSION;
		end else if (tbad_step) begin
			push.sts.status = ST_TYPE;
		end else if (lbad_step || {32'd0, bpos_step} != decl_step + 64'(HDR_BYTES)) begin
			push.sts.status = ST_LENGTH;
		end else begin
			push.sts.status       = ST_OK;
			push.sts.record_count = rec_wide[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			bpos_q  <= '0;
			decl_q  <= '0;
			fidx_q  <= '0;
			tag_q   <= '0;
			acc_q   <= '0;
			vleft_q <= '0;
			brem_q  <= '0;
			rec_q   <= '0;
			vbad_q  <= 1'b0;
			tbad_q  <= 1'b0;
			lbad_q  <= 1'b0;
		end else if (valid) begin
			if (item.end_of_message) begin
				phase_q <= PH_HEADER;
				bpos_q  <= '0;
				decl_q  <= '0;
				fidx_q  <= '0;
				tag_q   <= '0;
				acc_q   <= '0;
				vleft_q <= '0;
				brem_q  <= '0;
				rec_q   <= '0;
				vbad_q  <= 1'b0;
				tbad_q  <= 1'b0;
				lbad_q  <= 1'b0;
			end else begin
				phase_q <= phase_step;
				bpos_q  <= bpos_step;
				decl_q  <= decl_step;
				fidx_q  <= fidx_step;
				tag_q   <= tag_step;
				acc_q   <= acc_step;
				vleft_q <= vleft_step;
				brem_q  <= brem_step;
				rec_q   <= rec_step;
				vbad_q  <= vbad_step;
				tbad_q  <= tbad_step;
				lbad_q  <= lbad_step;
			end
		end
	end

endmodule

>>> rtl/core/tlvd_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one while out_ready is high.
// Depends on tlvd_pkg.
module tlvd_result_fifo
	import tlvd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  push_t                 push,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	output logic [FIFO_CNT_W-1:0] count
);

	out_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_b;
	logic [FIFO_CNT_W-1:0] n_push;

	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_q];
	assign count     = count_q;
	assign pop       = out_valid && out_ready;
	assign wr_b      = wr_q + FIFO_PTR_W'(push.rec_valid);
	assign n_push    = FIFO_CNT_W'(push.rec_valid) + FIFO_CNT_W'(push.sts_valid);

	always_ff @(posedge clk) begin
		if (push.rec_valid) mem_q[wr_q] <= push.rec;
		if (push.sts_valid) mem_q[wr_b] <= push.sts;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_PTR_W'(n_push);
			rd_q    <= rd_q + FIFO_PTR_W'(pop);
			count_q <= count_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule

>>> rtl/core/tlv_message_deframer_unit.sv
// Path: an accepted byte transaction is held in the input register (s1); the parser's results
// for it are written from there into the result queue, which hands out result transactions.
// Throughput: one byte per cycle; a byte may yield a record and a status, drained one
// per cycle while out_ready is high, through an 8-entry result queue; in_ready drops
// while held results plus two for the byte in the input register would exceed six.
// Reset: arst_n clears parse state, queue and config (max_records 4, others 0).
// Depends on tlvd_pkg, tlvd_parser, tlvd_result_fifo.
module tlv_message_deframer_unit
	import tlvd_pkg::*;
#(
	parameter int unsigned RECORD_COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	in_item_t              item_s1;
	push_t                 push;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W:0]   committed;

	// queue slots already owed: held results plus two for the byte in s1
	assign committed = {1'b0, fifo_count} + (valid_s1 ? (FIFO_CNT_W+1)'(2) : '0);
	assign in_ready  = committed <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_records      <= 8'd4;
			cfg_q.check_enable     <= 1'b0;
			cfg_q.expected_version <= 8'd0;
			cfg_q.expected_type    <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_RECORDS:  cfg_q.max_records      <= cfg_wdata;
				CFG_CHECK_ENABLE: cfg_q.check_enable     <= cfg_wdata[0];
				CFG_EXP_VERSION:  cfg_q.expected_version <= cfg_wdata;
				CFG_EXP_TYPE:     cfg_q.expected_type    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	tlvd_parser #(
		.RECORD_COUNT_BITS(RECORD_COUNT_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.push   (push)
	);

	tlvd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.count     (fifo_count)
	);

	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_eom_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.end_of_message) |-> ##2 out_valid)
		else $error("final byte produced no result");

	a_record_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.result_kind == KIND_RECORD) |->
		(!out_data.last && out_data.status == ST_OK))
		else $error("record result carries status fields");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.result_kind == KIND_STATUS) |-> out_data.last)
		else $error("status result without last");

endmodule

>>> verif/tb.sv
// Testbench for tlv_message_deframer_unit: byte transactions in, record and status results out.
// Results are checked against an in-bench deframer model, across register settings and idling.
// Depends on tlvd_pkg and the block's RTL.
module tb;
	import tlvd_pkg::*;

	localparam int          CNT_BITS    = 8;
	localparam logic [63:0] HEADER_LEN  = 64'd10;
	localparam logic [63:0] REC_HDR_LEN = 64'd5;
	localparam logic [63:0] BODY_LIMIT  = 64'h0000_0000_FFFF_FFF5;
	localparam int          STALL_LIMIT = 5000;
	localparam int          SETTLE      = 8;
	localparam int          ITEMS       = 1100;
	localparam int          PHASES      = 8;
	localparam int          HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
		logic       typed;
		logic [1:0] st;
		logic [7:0] cnt;
	} stim_row_t;

	// short header; one empty record; oversized body length
	stim_row_t dir_rows [26] = '{
		'{8'hFF, 1'b1, 1'b1, ST_LENGTH, 8'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h00, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h00, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h00, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h00, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h05, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h00, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'h00, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'h00, 1'b1, 1'b1, ST_OK, 8'd1},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}, '{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'd0},
		'{8'hFF, 1'b1, 1'b1, ST_LENGTH, 8'd0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	// register copies
	logic [7:0] cap_reg = 8'd4;
	logic       check_reg = 1'b0;
	logic [7:0] version_reg = 8'd0;
	logic [7:0] type_reg = 8'd0;

	// message state
	phase_t      msg_phase;
	logic [31:0] msg_pos;
	logic [63:0] body_len;
	logic [2:0]  field_idx;
	logic [7:0]  cur_tag;
	logic [31:0] len_acc;
	logic [31:0] value_left;
	logic [7:0]  rec_seen;
	logic        version_bad;
	logic        type_bad;
	logic        length_bad;

	out_item_t results_due[$];
	out_item_t oldest;
	int        failures = 0;
	int        bytes_sent = 0;
	int        quiet_cycles = 0;
	int        out_hold = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	tlv_message_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void clear_message();
		msg_phase = PH_HEADER;
		msg_pos = '0;
		body_len = '0;
		field_idx = '0;
		cur_tag = '0;
		len_acc = '0;
		value_left = '0;
		rec_seen = '0;
		version_bad = 1'b0;
		type_bad = 1'b0;
		length_bad = 1'b0;
	endfunction

	// body bytes still to come after the byte at pos
	function automatic logic [63:0] body_after(input logic [31:0] pos);
		return body_len - ({32'd0, pos} + 64'd1 - HEADER_LEN);
	endfunction

	function automatic int capacity();
		int c;
		c = (cap_reg == 8'd0) ? 1 : int'(cap_reg);
		if (c > (1 << CNT_BITS) - 1) c = (1 << CNT_BITS) - 1;
		return c;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic eom);
		logic [31:0] pos;
		logic [63:0] left;
		out_item_t   r;
		pos = msg_pos;
		r = '0;
		case (msg_phase)
		PH_HEADER: begin
			if (pos == 32'd0) begin
				if (check_reg && b != version_reg) version_bad = 1'b1;
			end else if (pos == 32'd1) begin
				if (check_reg && b != type_reg) type_bad = 1'b1;
			end else begin
				body_len = {body_len[55:0], b};
			end
			if (pos == HEADER_LEN[31:0] - 32'd1) begin
				if (body_len > BODY_LIMIT) begin
					length_bad = 1'b1;
					msg_phase = PH_DONE;
				end else if (body_len == 64'd0) begin
					msg_phase = PH_DONE;
				end else begin
					msg_phase = PH_RECHDR;
					field_idx = 3'd0;
				end
			end
		end
		PH_RECHDR: begin
			if (field_idx == 3'd0) begin
				if (body_after(pos) + 64'd1 < REC_HDR_LEN) begin
					length_bad = 1'b1;
					msg_phase = PH_DONE;
				end else begin
					cur_tag = b;
					len_acc = '0;
					field_idx = 3'd1;
				end
			end else begin
				len_acc = {len_acc[23:0], b};
				field_idx = field_idx + 3'd1;
				if (field_idx == REC_HDR_LEN[2:0]) begin
					left = body_after(pos);
					field_idx = 3'd0;
					if ({32'd0, len_acc} > left) begin
						length_bad = 1'b1;
						msg_phase = PH_DONE;
					end else begin
						left = left - {32'd0, len_acc};
						if (!version_bad && !type_bad && !length_bad) begin
							r.result_kind = KIND_RECORD;
							r.record_tag = cur_tag;
							r.value_length = len_acc;
							r.value_offset = pos + 32'd1;
							results_due.push_back(r);
						end
						rec_seen = rec_seen + 8'd1;
						if (int'(rec_seen) >= capacity()) begin
							if (left != 64'd0) length_bad = 1'b1;
							msg_phase = PH_DONE;
						end else if (len_acc != 32'd0) begin
							value_left = len_acc;
							msg_phase = PH_VALUE;
						end else if (left == 64'd0) begin
							msg_phase = PH_DONE;
						end
					end
				end
			end
		end
		PH_VALUE: begin
			value_left = value_left - 32'd1;
			if (value_left == 32'd0) begin
				if (body_after(pos) == 64'd0) msg_phase = PH_DONE;
				else msg_phase = PH_RECHDR;
				field_idx = 3'd0;
			end
		end
		default: ;
		endcase
		if (msg_pos == 32'hFFFF_FFFF) length_bad = 1'b1;
		else msg_pos = msg_pos + 32'd1;
		if (eom) begin
			r = '0;
			r.result_kind = KIND_STATUS;
			r.last = 1'b1;
			if ({32'd0, msg_pos} < HEADER_LEN) begin
				r.status = ST_LENGTH;
			end else if (version_bad) begin
				r.status = ST_VERSION;
			end else if (type_bad) begin
				r.status = ST_TYPE;
			end else if (length_bad || {32'd0, msg_pos} != body_len + HEADER_LEN) begin
				r.status = ST_LENGTH;
			end else begin
				r.status = ST_OK;
				r.record_count = rec_seen;
			end
			results_due.push_back(r);
			clear_message();
		end
	endfunction

	function automatic string show(input out_item_t r);
		return $sformatf("kind=%0d tag=%02h len=%08h off=%08h st=%0d cnt=%0d last=%0d",
			r.result_kind, r.record_tag, r.value_length, r.value_offset,
			r.status, r.record_count, r.last);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eom);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, end_of_message: eom};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		deframe_byte(b, eom);
		bytes_sent++;
	endtask

	// drop valid, wait out every result, then let the pipe go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_MAX_RECORDS: cap_reg = val;
		CFG_CHECK_ENABLE: check_reg = val[0];
		CFG_EXP_VERSION: version_reg = val;
		CFG_EXP_TYPE: type_reg = val;
		default: ;
		endcase
	endtask

	// mostly well-formed messages; some bad lengths, version or type bytes, truncation, trailing bytes
	task automatic send_message();
		logic [7:0]  msg[$];
		logic [7:0]  body[$];
		logic [63:0] decl;
		logic [31:0] rlen;
		logic [7:0]  ver_b;
		logic [7:0]  type_b;
		int          nrec;
		int          vlen;
		int          flavor;
		int          count;
		nrec = $urandom_range((capacity() < 6) ? capacity() + 1 : 6);
		for (int i = 0; i < nrec; i++) begin
			vlen = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3);
			rlen = 32'(vlen);
			flavor = $urandom_range(29);
			if (flavor == 0) rlen = $urandom();
			else if (flavor == 1) rlen = 32'(vlen + 1);
			body.push_back(8'($urandom_range(255)));
			for (int k = 3; k >= 0; k--) body.push_back(rlen[8*k +: 8]);
			repeat (vlen) body.push_back(8'($urandom_range(255)));
		end
		decl = 64'(body.size());
		flavor = $urandom_range(15);
		case (flavor)
		0: decl = decl + 64'($urandom_range(1, 4));
		1: if (decl != 0) decl = decl - 64'd1;
		2: decl = {$urandom(), $urandom()};
		3: decl = BODY_LIMIT + 64'($urandom_range(1));
		default: ;
		endcase
		ver_b = (check_reg && $urandom_range(7) != 0) ? version_reg : 8'($urandom_range(255));
		type_b = (check_reg && $urandom_range(7) != 0) ? type_reg : 8'($urandom_range(255));
		msg.push_back(ver_b);
		msg.push_back(type_b);
		for (int k = 7; k >= 0; k--) msg.push_back(decl[8*k +: 8]);
		foreach (body[i]) msg.push_back(body[i]);
		if (flavor == 5) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
		count = msg.size();
		if (flavor == 4) count = $urandom_range(1, count);
		for (int i = 0; i < count; i++) send_byte(msg[i], i == count - 1);
	endtask

	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold = out_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result %s", $time, show(out_data));
				failures++;
			end else begin
				oldest = results_due.pop_front();
				if (out_data !== oldest) begin
					$display("%0t: result mismatch\n  expected %s\n  actual   %s",
						$time, show(oldest), show(out_data));
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL tlv_message_deframer_unit");
			$finish;
		end
	end

	initial begin
		out_item_t  typed_sts;
		logic [7:0] mx;
		logic [7:0] ck;
		logic [7:0] vr;
		logic [7:0] ty;
		clear_message();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].data, dir_rows[i].eom);
			if (dir_rows[i].typed) begin
				typed_sts = '0;
				typed_sts.result_kind = KIND_STATUS;
				typed_sts.status = dir_rows[i].st;
				typed_sts.record_count = dir_rows[i].cnt;
				typed_sts.last = 1'b1;
				results_due[results_due.size() - 1] = typed_sts;
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
			0: begin
				mx = 8'd3; ck = 8'd0; vr = 8'h00; ty = 8'h00;
			end
			1: begin
				mx = 8'd1; ck = 8'd1; vr = 8'h00; ty = 8'hFF;
			end
			2: begin
				mx = 8'd255; ck = 8'd1; vr = 8'hFF; ty = 8'h00;
			end
			3: begin
				mx = 8'd0; ck = 8'd0;
				vr = 8'($urandom_range(255)); ty = 8'($urandom_range(255));
			end
			default: begin
				mx = 8'($urandom_range(1, 6)); ck = 8'($urandom_range(1));
				vr = 8'($urandom_range(255)); ty = 8'($urandom_range(255));
			end
			endcase
			// junk in the upper bits of the enable write
			ck = {7'($urandom_range(127)), ck[0]};
			write_reg(CFG_MAX_RECORDS, mx);
			write_reg(CFG_CHECK_ENABLE, ck);
			write_reg(CFG_EXP_VERSION, vr);
			write_reg(CFG_EXP_TYPE, ty);
			send_idle_pct = (ph % 4 == 1) ? 77 : (ph % 4 == 3) ? 16 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 77 : (ph % 4 == 3) ? 16 : 0;
			if (ph == 0) out_hold = HOLD_CYCLES;
			while (bytes_sent < (ph + 1) * ITEMS / PHASES) send_message();
		end
		settle();

		if (failures == 0)
			$display("PASS tlv_message_deframer_unit");
		else
			$display("FAIL tlv_message_deframer_unit");
		$finish;
	end

endmodule
